### src/swm_pkg.sv
// Shared widths, defaults and command codes of the sliding-window median core.
`default_nettype none
package swm_pkg;

   localparam int WINDOW_DEFAULT = 8;
   localparam int MODE_W         = 2;
   localparam int SAMPLE_W       = 16;
   localparam int MEDIAN_W       = 17;
   localparam int FILL_W         = 7;

   // request commands
   localparam logic [MODE_W-1:0] MODE_ADD         = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR       = 2'd1;
   localparam logic [MODE_W-1:0] MODE_KEEP_NEWEST = 2'd2;

endpackage
`default_nettype wire

### src/swm_ram.sv
// Simple dual-port RAM, one write and one read port, registered read data.
`default_nettype none
module swm_ram #(
   parameter int DEPTH = swm_pkg::WINDOW_DEFAULT,
   parameter int WIDTH = swm_pkg::SAMPLE_W
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### src/sliding_window_median_core.sv
// Sliding-window median core: sample ring, sorted copy and the update sequencer.
//
//   channel  | direction | ports                                   | moves
//   ---------+-----------+-----------------------------------------+--------------------------
//   req      | in        | req_valid, req_stall, req_mode,         | one command beat
//            |           | req_sample                              |
//   rsp      | out       | rsp_valid, rsp_stall, rsp_median_times_ | one result beat per
//            |           | two, rsp_median_valid, rsp_fill_count,  | command beat
//            |           | rsp_was_full                            |
//
// Sequencing: one command at a time. Clear, the reserved code and keep-newest on an empty
// window go straight to the median step; keep-newest on a held window first copies the
// newest sample; an add is paced by the one read port of the sorted copy, and an add into
// a full window needs a removal sweep and an insertion sweep.
// Reset: synchronous, active high; empties the window. No clearing sweep is needed.
// Stalls: a finished beat waits in the rsp register while the next command is taken.
`default_nettype none
module sliding_window_median_core #(
   parameter int WINDOW = swm_pkg::WINDOW_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic        [swm_pkg::MODE_W-1:0]   req_mode,
   input  wire logic signed [swm_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed      [swm_pkg::MEDIAN_W-1:0] rsp_median_times_two,
   output logic                                     rsp_median_valid,
   output logic             [swm_pkg::FILL_W-1:0]   rsp_fill_count,
   output logic                                     rsp_was_full
);

   localparam int IDX_W = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SW    = swm_pkg::SAMPLE_W;
   localparam int MW    = swm_pkg::MEDIAN_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OLD,
      ST_NEWEST,
      ST_REMOVE,
      ST_INSERT,
      ST_MED,
      ST_MED_HI,
      ST_MED_SUM,
      ST_FIN
   } state_type;

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        wp_ff, wp_in;
   logic [CNT_W-1:0]        held_ff, held_in;
   logic [CNT_W-1:0]        len_ff, len_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    pend_ff, pend_in;
   logic [IDX_W-1:0]        pend_idx_ff, pend_idx_in;
   logic                    found_ff, found_in;
   logic                    was_full_ff, was_full_in;
   logic signed [SW-1:0]    sample_ff, sample_in;
   logic signed [SW-1:0]    old_ff, old_in;
   logic signed [SW-1:0]    carry_ff, carry_in;
   logic signed [SW-1:0]    lo_ff, lo_in;
   logic signed [MW-1:0]    res_ff, res_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [MW-1:0]    rsp_med_ff, rsp_med_in;
   logic                    rsp_mvalid_ff, rsp_mvalid_in;
   logic [swm_pkg::FILL_W-1:0] rsp_fill_ff, rsp_fill_in;
   logic                    rsp_full_ff, rsp_full_in;

   // ring memory port signals
   logic                    ring_we, ring_re;
   logic [IDX_W-1:0]        ring_waddr, ring_raddr;
   logic signed [SW-1:0]    ring_wdata, ring_rdata;
   // sorted copy port signals
   logic                    srt_we, srt_re;
   logic [IDX_W-1:0]        srt_waddr, srt_raddr;
   logic signed [SW-1:0]    srt_wdata, srt_rdata;

   logic [IDX_W-1:0]        wp_next;
   logic                    win_full;
   logic                    issue;
   logic                    pass_done;
   logic [CNT_W-1:0]        lo_idx, hi_idx;

   // Sample ring: slot wp_ff holds the newest sample.
   swm_ram #(.DEPTH(WINDOW), .WIDTH(SW)) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (ring_wdata),
      .rd_en   (ring_re),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

   // Sorted copy: slots 0..held-1 hold the window in ascending order.
   swm_ram #(.DEPTH(WINDOW), .WIDTH(SW)) u_sorted (
      .clock   (clock),
      .wr_en   (srt_we),
      .wr_addr (srt_waddr),
      .wr_data (srt_wdata),
      .rd_en   (srt_re),
      .rd_addr (srt_raddr),
      .rd_data (srt_rdata)
   );

   assign wp_next   = (wp_ff == IDX_W'(WINDOW - 1)) ? '0 : wp_ff + 1'b1;
   assign win_full  = (held_ff == CNT_W'(WINDOW));
   // a sweep issues one read a cycle and handles its data the cycle after
   assign issue     = (cnt_ff < len_ff);
   assign pass_done = !issue && !pend_ff;
   assign lo_idx    = (held_ff - 1'b1) >> 1;
   assign hi_idx    = held_ff >> 1;

   always_comb begin
      state_in    = state_ff;
      wp_in       = wp_ff;
      held_in     = held_ff;
      len_in      = len_ff;
      cnt_in      = cnt_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      found_in    = found_ff;
      was_full_in = was_full_ff;
      sample_in   = sample_ff;
      old_in      = old_ff;
      carry_in    = carry_ff;
      lo_in       = lo_ff;
      res_in      = res_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_med_in    = rsp_med_ff;
      rsp_mvalid_in = rsp_mvalid_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_full_in   = rsp_full_ff;

      ring_we    = 1'b0;
      ring_waddr = wp_ff;
      ring_wdata = sample_ff;
      ring_re    = 1'b0;
      ring_raddr = wp_next;
      srt_we     = 1'b0;
      srt_waddr  = '0;
      srt_wdata  = carry_ff;
      srt_re     = 1'b0;
      srt_raddr  = cnt_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in   = req_sample;
               was_full_in = 1'b0;
               cnt_in      = '0;
               found_in    = 1'b0;
               unique case (req_mode)
                  swm_pkg::MODE_ADD: begin
                     wp_in = wp_next;
                     if (win_full) begin
                        // fetch the oldest sample before it is overwritten
                        ring_re     = 1'b1;
                        was_full_in = 1'b1;
                        state_in    = ST_OLD;
                     end else begin
                        ring_we    = 1'b1;
                        ring_waddr = wp_next;
                        ring_wdata = req_sample;
                        held_in    = held_ff + 1'b1;
                        len_in     = held_ff;
                        carry_in   = req_sample;
                        state_in   = ST_INSERT;
                     end
                  end
                  swm_pkg::MODE_CLEAR: begin
                     held_in  = '0;
                     wp_in    = IDX_W'(WINDOW - 1);
                     state_in = ST_MED;
                  end
                  swm_pkg::MODE_KEEP_NEWEST: begin
                     if (held_ff == '0) begin
                        wp_in    = IDX_W'(WINDOW - 1);
                        state_in = ST_MED;
                     end else begin
                        ring_re    = 1'b1;
                        ring_raddr = wp_ff;
                        state_in   = ST_NEWEST;
                     end
                  end
                  default: begin
                     state_in = ST_MED;
                  end
               endcase
            end
         end
         ST_OLD: begin
            old_in     = ring_rdata;
            ring_we    = 1'b1;
            ring_waddr = wp_ff;
            ring_wdata = sample_ff;
            len_in     = held_ff;
            state_in   = ST_REMOVE;
         end
         ST_NEWEST: begin
            ring_we    = 1'b1;
            ring_waddr = '0;
            ring_wdata = ring_rdata;
            srt_we     = 1'b1;
            srt_waddr  = '0;
            srt_wdata  = ring_rdata;
            held_in    = CNT_W'(1);
            wp_in      = '0;
            state_in   = ST_MED;
         end
         ST_REMOVE: begin
            srt_re      = issue;
            pend_in     = issue;
            pend_idx_in = cnt_ff[IDX_W-1:0];
            if (issue) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (pend_ff) begin
               // drop the first copy of the oldest sample, close the gap
               priority if (!found_ff && srt_rdata == old_ff) begin
                  found_in = 1'b1;
               end else if (found_ff) begin
                  srt_we    = 1'b1;
                  srt_waddr = pend_idx_ff - 1'b1;
                  srt_wdata = srt_rdata;
               end else begin
                  // below the oldest sample: hold the slot as it is
                  srt_we = 1'b0;
               end
            end
            if (pass_done) begin
               len_in   = held_ff - 1'b1;
               carry_in = sample_ff;
               cnt_in   = '0;
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            srt_re      = issue;
            pend_in     = issue;
            pend_idx_in = cnt_ff[IDX_W-1:0];
            if (issue) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (pend_ff) begin
               // keep the smaller in place, carry the larger up
               srt_we    = 1'b1;
               srt_waddr = pend_idx_ff;
               if (carry_ff < srt_rdata) begin
                  srt_wdata = carry_ff;
                  carry_in  = srt_rdata;
               end else begin
                  srt_wdata = srt_rdata;
               end
            end
            if (pass_done) begin
               srt_we    = 1'b1;
               srt_waddr = len_ff[IDX_W-1:0];
               srt_wdata = carry_ff;
               state_in  = ST_MED;
            end
         end
         ST_MED: begin
            if (held_ff == '0) begin
               res_in   = '0;
               state_in = ST_FIN;
            end else begin
               srt_re    = 1'b1;
               srt_raddr = lo_idx[IDX_W-1:0];
               state_in  = ST_MED_HI;
            end
         end
         ST_MED_HI: begin
            lo_in     = srt_rdata;
            srt_re    = 1'b1;
            srt_raddr = hi_idx[IDX_W-1:0];
            state_in  = ST_MED_SUM;
         end
         ST_MED_SUM: begin
            // both middle slots coincide for an odd count, giving twice the value
            res_in   = MW'(lo_ff) + MW'(srt_rdata);
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_med_in    = res_ff;
               rsp_mvalid_in = (held_ff != '0);
               rsp_fill_in   = swm_pkg::FILL_W'(held_ff);
               rsp_full_in   = was_full_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= IDX_W'(WINDOW - 1);
         held_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         held_ff      <= held_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff        <= len_in;
      cnt_ff        <= cnt_in;
      pend_idx_ff   <= pend_idx_in;
      found_ff      <= found_in;
      was_full_ff   <= was_full_in;
      sample_ff     <= sample_in;
      old_ff        <= old_in;
      carry_ff      <= carry_in;
      lo_ff         <= lo_in;
      res_ff        <= res_in;
      rsp_med_ff    <= rsp_med_in;
      rsp_mvalid_ff <= rsp_mvalid_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_full_ff   <= rsp_full_in;
   end

   assign req_stall            = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_median_times_two = rsp_med_ff;
   assign rsp_median_valid     = rsp_mvalid_ff;
   assign rsp_fill_count       = rsp_fill_ff;
   assign rsp_was_full         = rsp_full_ff;

endmodule
`default_nettype wire

### src/swm_checker.sv
// Port-level checks on the median core, bound to its top level.
`default_nettype none
module swm_checker #(
   parameter int WINDOW = swm_pkg::WINDOW_DEFAULT
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic signed [swm_pkg::MEDIAN_W-1:0] rsp_median_times_two,
   input wire logic                                rsp_median_valid,
   input wire logic        [swm_pkg::FILL_W-1:0]   rsp_fill_count,
   input wire logic                                rsp_was_full
);

   // hold a stalled beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_median_times_two)
         && $stable(rsp_fill_count) && $stable(rsp_was_full))
      else $error("stalled result beat changed");

   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_median_valid == (rsp_fill_count != '0))
      else $error("median_valid disagrees with fill_count");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_median_valid |-> rsp_median_times_two == '0)
      else $error("empty window reports nonzero median");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_full |-> rsp_fill_count == swm_pkg::FILL_W'(WINDOW))
      else $error("was_full set below a full window");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fill_count <= swm_pkg::FILL_W'(WINDOW))
      else $error("fill_count beyond window");

endmodule

bind sliding_window_median_core swm_checker #(.WINDOW(WINDOW)) u_swm_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_median_times_two (rsp_median_times_two),
   .rsp_median_valid     (rsp_median_valid),
   .rsp_fill_count       (rsp_fill_count),
   .rsp_was_full         (rsp_was_full)
);
`default_nettype wire

### tb/sliding_window_median_core_tb.sv
// Self-checking testbench for the sliding-window median core.
module sliding_window_median_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW = swm_pkg::WINDOW_DEFAULT;

   // The package leaves code 3 unnamed; the core must treat it as a no-op that still reports.
   localparam logic [swm_pkg::MODE_W-1:0] MODE_RESERVED = 2'd3;

   // Leave ample room after the last beat for the longest command, an add into a full window.
   localparam int DRAIN_CYCLES = 2 * WINDOW + 40;
   // Worst case per command: the busy time of a full-window add, the longest drawn gap on the
   // request side and the longest result-side stall. Roughly 1150 commands; allow 5x that total.
   localparam int CYCLE_LIMIT  = 300000;

   typedef struct {
      logic signed [swm_pkg::MEDIAN_W-1:0] med2;
      logic                                med_valid;
      logic        [swm_pkg::FILL_W-1:0]   fill;
      logic                                full;
   } median_result_type;

   logic                                clock      = 1'b0;
   logic                                reset      = 1'b1;
   logic                                req_valid  = 1'b0;
   logic                                req_stall;
   logic        [swm_pkg::MODE_W-1:0]   req_mode   = swm_pkg::MODE_ADD;
   logic signed [swm_pkg::SAMPLE_W-1:0] req_sample = '0;
   logic                                rsp_valid;
   logic                                rsp_stall  = 1'b0;
   logic signed [swm_pkg::MEDIAN_W-1:0] rsp_median_times_two;
   logic                                rsp_median_valid;
   logic        [swm_pkg::FILL_W-1:0]   rsp_fill_count;
   logic                                rsp_was_full;

   // Predictor state: our own copy of the sample ring, the newest slot and the fill level.
   logic signed [swm_pkg::SAMPLE_W-1:0] win_ring [WINDOW];
   int                                  win_newest = WINDOW - 1;
   int                                  win_count  = 0;

   // Results predicted at request acceptance, oldest first.
   median_result_type pending_medians [$];

   // When low, both sides run without gaps or stalls.
   bit idle_on = 1'b1;

   int error_count = 0;
   int cycle_count = 0;
   int n_adds      = 0;
   int n_overwrite = 0;
   int n_clears    = 0;
   int n_keeps     = 0;
   int n_reserved  = 0;
   int n_results   = 0;

   sliding_window_median_core #(
      .WINDOW(WINDOW)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_sample          (req_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_median_times_two(rsp_median_times_two),
      .rsp_median_valid    (rsp_median_valid),
      .rsp_fill_count      (rsp_fill_count),
      .rsp_was_full        (rsp_was_full)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Per-beat wait drawn by either side; zero while a no-idle stretch is running.
   function automatic int draw_wait();
      return idle_on ? $urandom_range(0, 12) : 0;
   endfunction

   // Bias sample values toward the extremes and toward small clustered values,
   // so ties and sign crossings in the sort show up often.
   function automatic logic signed [swm_pkg::SAMPLE_W-1:0] draw_sample();
      logic signed [swm_pkg::SAMPLE_W-1:0] value;
      case ($urandom_range(0, 9))
         0: value = 16'sh8000;
         1: value = 16'sh7FFF;
         2, 3: value = swm_pkg::SAMPLE_W'($urandom_range(0, 8) - 4);
         default: value = swm_pkg::SAMPLE_W'($urandom);
      endcase
      return value;
   endfunction

   // Apply one command to the predicted window and return the result it must produce.
   function automatic median_result_type predict_median(
         input logic        [swm_pkg::MODE_W-1:0]   mode,
         input logic signed [swm_pkg::SAMPLE_W-1:0] sample);
      median_result_type result;
      int                sorted [WINDOW];
      int                value;
      int                j;
      int                med2;
      result.full = 1'b0;
      case (mode)
         swm_pkg::MODE_ADD: begin
            // Advance the newest slot with wrap; once full, the oldest is overwritten.
            win_newest = (win_newest + 1 < WINDOW) ? win_newest + 1 : 0;
            win_ring[win_newest] = sample;
            if (win_count < WINDOW) begin
               win_count++;
            end else begin
               result.full = 1'b1;
            end
         end
         swm_pkg::MODE_CLEAR: begin
            win_count  = 0;
            win_newest = WINDOW - 1;
         end
         swm_pkg::MODE_KEEP_NEWEST: begin
            // Empty window: behaves as a clear. Otherwise the newest moves to slot 0.
            if (win_count == 0) begin
               win_newest = WINDOW - 1;
            end else begin
               win_ring[0] = win_ring[win_newest];
               win_newest  = 0;
               win_count   = 1;
            end
         end
         default: ;
      endcase
      // Held samples always sit in slots 0..count-1; sort them ascending.
      for (int i = 0; i < win_count; i++) begin
         value = win_ring[i];
         j = i;
         while (j > 0 && sorted[j - 1] > value) begin
            sorted[j] = sorted[j - 1];
            j--;
         end
         sorted[j] = value;
      end
      med2 = 0;
      if (win_count > 0) begin
         med2 = (win_count % 2 == 1) ? 2 * sorted[win_count / 2]
                                     : sorted[win_count / 2] + sorted[win_count / 2 - 1];
      end
      result.med2      = swm_pkg::MEDIAN_W'(med2);
      result.med_valid = (win_count > 0);
      result.fill      = swm_pkg::FILL_W'(win_count);
      return result;
   endfunction

   // Send one command beat. Entered and left at a rising edge; valid stays high into
   // the next beat when no gap is drawn, so it is never dropped and raised in one step.
   task automatic send_command(input logic        [swm_pkg::MODE_W-1:0]   mode,
                               input logic signed [swm_pkg::SAMPLE_W-1:0] sample);
      int                gap;
      median_result_type predicted;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_mode   <= mode;
      req_sample <= sample;
      // Hold the payload until the core takes the beat.
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = predict_median(mode, sample);
      pending_medians.push_back(predicted);
      case (mode)
         swm_pkg::MODE_ADD:         n_adds++;
         swm_pkg::MODE_CLEAR:       n_clears++;
         swm_pkg::MODE_KEEP_NEWEST: n_keeps++;
         default:                   n_reserved++;
      endcase
      if (predicted.full) n_overwrite++;
   endtask

   // Result side: stall a drawn number of cycles before each beat, then release
   // and wait for the beat to go through.
   initial begin : result_backpressure
      int hold;
      forever begin
         hold = draw_wait();
         rsp_stall <= (hold > 0);
         if (hold > 0) begin
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
      end
   end

   // Compare every accepted result beat with the oldest prediction.
   always @(posedge clock) begin : result_check
      median_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         n_results++;
         if (pending_medians.size() == 0) begin
            error_count++;
            $display("%0t: result beat with none pending: med2=%0d valid=%b fill=%0d full=%b",
                     $time, rsp_median_times_two, rsp_median_valid, rsp_fill_count,
                     rsp_was_full);
         end else begin
            want = pending_medians.pop_front();
            if (rsp_median_times_two !== want.med2) begin
               error_count++;
               $display("%0t: median_times_two expected %0d, got %0d",
                        $time, want.med2, rsp_median_times_two);
            end
            if (rsp_median_valid !== want.med_valid) begin
               error_count++;
               $display("%0t: median_valid expected %b, got %b",
                        $time, want.med_valid, rsp_median_valid);
            end
            if (rsp_fill_count !== want.fill) begin
               error_count++;
               $display("%0t: fill_count expected %0d, got %0d",
                        $time, want.fill, rsp_fill_count);
            end
            if (rsp_was_full !== want.full) begin
               error_count++;
               $display("%0t: was_full expected %b, got %b",
                        $time, want.full, rsp_was_full);
            end
         end
      end
   end

   // Commands on an empty window, output extremes, a wrap into a full window,
   // the reserved code, keep-newest and clear.
   task automatic test_empty_and_extremes();
      send_command(swm_pkg::MODE_KEEP_NEWEST, 16'sh1234); // keep newest while empty
      send_command(swm_pkg::MODE_CLEAR, -16'sd1);
      send_command(MODE_RESERVED, 16'sh7FFF);              // reserved code, empty window
      send_command(swm_pkg::MODE_ADD, 16'sh8000);          // lowest doubled median
      send_command(swm_pkg::MODE_ADD, 16'sh7FFF);          // even count sums the middle pair
      send_command(swm_pkg::MODE_ADD, 16'sh8000);
      send_command(swm_pkg::MODE_ADD, 16'sh7FFF);
      send_command(swm_pkg::MODE_ADD, 16'sd0);
      send_command(swm_pkg::MODE_ADD, -16'sd1);
      send_command(swm_pkg::MODE_ADD, 16'sd1);
      send_command(swm_pkg::MODE_ADD, 16'sd12345);         // window now full
      send_command(swm_pkg::MODE_ADD, 16'sh8000);          // overwrite the oldest
      send_command(MODE_RESERVED, 16'sd0);                 // reserved code, full window
      send_command(swm_pkg::MODE_KEEP_NEWEST, 16'sd5);
      send_command(swm_pkg::MODE_ADD, 16'sh7FFF);
      send_command(swm_pkg::MODE_CLEAR, 16'sd0);
      send_command(swm_pkg::MODE_ADD, 16'sh7FFF);          // highest doubled median
      send_command(swm_pkg::MODE_KEEP_NEWEST, -16'sd5);
      send_command(swm_pkg::MODE_ADD, 16'sd5);
   endtask

   // Mostly well-formed runs: clear the window or cut it to its newest, then 1 to 3*WINDOW adds
   // that can wrap it more than once. Some extend it; the rest is noise in every mode code.
   task automatic test_random_windows(input int n_items);
      int                          sent;
      int                          run_len;
      logic [swm_pkg::MODE_W-1:0]  mode;
      sent = 0;
      while (sent < n_items) begin
         // Drop into a no-idle stretch now and then.
         idle_on = ($urandom_range(0, 4) != 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               send_command($urandom_range(0, 1) ? swm_pkg::MODE_CLEAR
                                                 : swm_pkg::MODE_KEEP_NEWEST,
                            draw_sample());
               run_len = $urandom_range(1, 3 * WINDOW);
               repeat (run_len) send_command(swm_pkg::MODE_ADD, draw_sample());
               sent += run_len + 1;
            end
            6, 7: begin
               // Extend the current window without resetting it.
               run_len = $urandom_range(1, WINDOW);
               repeat (run_len) send_command(swm_pkg::MODE_ADD, draw_sample());
               sent += run_len;
            end
            default: begin
               repeat ($urandom_range(1, 6)) begin
                  mode = swm_pkg::MODE_W'($urandom_range(0, 3));
                  send_command(mode, swm_pkg::SAMPLE_W'($urandom));
                  if (mode != MODE_RESERVED) sent++;
               end
            end
         endcase
      end
      idle_on = 1'b1;
   endtask

   // No gaps and no stalls: commands back to back, mostly adds.
   task automatic test_back_to_back(input int n_items);
      int sent;
      int pick;
      sent = 0;
      idle_on = 1'b0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 19);
         if (pick < 15) begin
            send_command(swm_pkg::MODE_ADD, draw_sample());
            sent++;
         end else if (pick < 17) begin
            send_command(swm_pkg::MODE_KEEP_NEWEST, draw_sample());
            sent++;
         end else if (pick < 19) begin
            send_command(swm_pkg::MODE_CLEAR, draw_sample());
            sent++;
         end else begin
            send_command(MODE_RESERVED, draw_sample());
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("%0t: timeout after %0d cycles, %0d results pending",
               $time, cycle_count, pending_medians.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : run_tests
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_extremes();
      test_random_windows(1000);
      test_back_to_back(130);
      req_valid <= 1'b0;
      // Drain: wait for every predicted beat, then watch for strays.
      while (pending_medians.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d adds (%0d into a full window), %0d clears, %0d keep-newest,",
               n_adds, n_overwrite, n_clears, n_keeps);
      $display("%0d reserved codes; %0d result beats checked, %0d mismatches.",
               n_reserved, n_results, error_count);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
